FILE: rtl/kclp_pkg.sv
package kclp_pkg;

	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 8;
	localparam int unsigned EventW = 4;
	localparam int unsigned ClickW = 3;

	typedef logic [7:0] cnt8_t;
	typedef logic [ClickW-1:0] click_t;
	typedef logic [EventW-1:0] event_t;
	typedef logic [CfgIdxW-1:0] cfg_idx_t;
	typedef logic [CfgDataW-1:0] cfg_data_t;

	// Register indexes of the configuration port.
	typedef enum logic [CfgIdxW-1:0] {
		REG_DEBOUNCE_LIMIT    = 3'd0,
		REG_UP_AGE_WHILE_HELD = 3'd1,
		REG_CLICK_WINDOW_LEN  = 3'd2,
		REG_HOLD_LIMIT        = 3'd3,
		REG_UP_AGE_LIMIT      = 3'd4,
		REG_HOLD_START        = 3'd5,
		REG_LONG_PRESS_TICKS  = 3'd6,
		REG_FIRST_PRESS_ONLY  = 3'd7
	} cfg_reg_t;

	localparam event_t EV_NONE    = 4'd0;
	localparam event_t EV_PRESS   = 4'd1;
	localparam event_t EV_RELEASE = 4'd2;
	localparam event_t EV_X1      = 4'd3;
	localparam event_t EV_LONG    = 4'd8;

	localparam click_t MAX_CLICKS = 3'd5;
	localparam cnt8_t DEBOUNCE_CAP = 8'd254;

endpackage

FILE: rtl/kclp_if.sv
interface kclp_in_if;
	logic valid;
	logic ready;
	logic pressed;
	modport source (output valid, output pressed, input ready);
	modport sink (input valid, input pressed, output ready);
endinterface

interface kclp_out_if;
	logic valid;
	logic ready;
	kclp_pkg::event_t event_code;
	modport source (output valid, output event_code, input ready);
	modport sink (input valid, input event_code, output ready);
endinterface

interface kclp_cfg_if;
	logic valid;
	logic ready;
	kclp_pkg::cfg_idx_t index;
	kclp_pkg::cfg_data_t data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/key_click_long_press_detector_unit.sv
// Key click and long-press detector.
// The in_ch channel takes one sampled key level (pressed) per poll tick; out_ch
// gives exactly one event code per accepted sample: none, press, release, one to
// five clicks, or long press. The cfg_ch channel writes the eight settings by
// register index; it is always ready and should be used only while no sample is
// in flight.
// An accepted sample is held in the input stage, evaluated combinationally
// against the debounce, click and hold counters, and its event code is
// registered in the output register when the input stage advances. One
// sample is taken every cycle while out_ch does not stall; a stall holds
// the input stage and the output register, as below.
// When out_ch stalls, the output register and input stage both hold, so in_ch
// keeps accepting until both are full and then drops ready.
// Reset clears all counters and flags and loads the default settings
// (debounce 3, click window 30, hold and age limits 255, long press at 200,
// press event only on the first click).
module key_click_long_press_detector_unit (
	input  logic clk,
	input  logic arst_n,
	kclp_in_if.sink    in_ch,
	kclp_out_if.source out_ch,
	kclp_cfg_if.sink   cfg_ch
);

	kclp_pkg::cnt8_t debounce_limit_q, up_age_while_held_q, click_window_len_q;
	kclp_pkg::cnt8_t hold_limit_q, up_age_limit_q, hold_start_q, long_press_ticks_q;
	logic first_press_only_q;

	kclp_pkg::cnt8_t debounce_cnt_q, release_age_q, hold_time_q, click_window_q;
	kclp_pkg::click_t click_cnt_q;
	logic is_held_q, is_released_q;

	kclp_pkg::cnt8_t debounce_cnt_d, release_age_d, hold_time_d, click_window_d;
	kclp_pkg::click_t click_cnt_d;
	logic is_held_d, is_released_d;
	kclp_pkg::event_t ev_d;
	kclp_pkg::cnt8_t lim;

	logic valid_s1, pressed_s1;
	logic out_valid_q;
	kclp_pkg::event_t event_q;
	logic advance;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_limit_q <= 8'd3;
			up_age_while_held_q <= 8'd0;
			click_window_len_q <= 8'd30;
			hold_limit_q <= 8'd255;
			up_age_limit_q <= 8'd255;
			hold_start_q <= 8'd0;
			long_press_ticks_q <= 8'd200;
			first_press_only_q <= 1'b1;
		end else if (cfg_ch.valid) begin
			unique case (kclp_pkg::cfg_reg_t'(cfg_ch.index))
				kclp_pkg::REG_DEBOUNCE_LIMIT:    debounce_limit_q <= cfg_ch.data;
				kclp_pkg::REG_UP_AGE_WHILE_HELD: up_age_while_held_q <= cfg_ch.data;
				kclp_pkg::REG_CLICK_WINDOW_LEN:  click_window_len_q <= cfg_ch.data;
				kclp_pkg::REG_HOLD_LIMIT:        hold_limit_q <= cfg_ch.data;
				kclp_pkg::REG_UP_AGE_LIMIT:      up_age_limit_q <= cfg_ch.data;
				kclp_pkg::REG_HOLD_START:        hold_start_q <= cfg_ch.data;
				kclp_pkg::REG_LONG_PRESS_TICKS:  long_press_ticks_q <= cfg_ch.data;
				kclp_pkg::REG_FIRST_PRESS_ONLY:  first_press_only_q <= cfg_ch.data[0];
				default: ;
			endcase
		end
	end

	// The input stage moves on when the output register is free or being drained.
	assign advance = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			pressed_s1 <= in_ch.pressed;
		end
	end

	always_comb begin
		lim = (debounce_limit_q > kclp_pkg::DEBOUNCE_CAP) ? kclp_pkg::DEBOUNCE_CAP
			: debounce_limit_q;
		ev_d = kclp_pkg::EV_NONE;
		debounce_cnt_d = debounce_cnt_q;
		release_age_d = release_age_q;
		hold_time_d = hold_time_q;
		click_cnt_d = click_cnt_q;
		click_window_d = click_window_q;
		is_held_d = is_held_q;
		is_released_d = is_released_q;

		if (pressed_s1) begin
			if (debounce_cnt_q < lim) begin
				debounce_cnt_d = debounce_cnt_q + 8'd1;
				release_age_d = up_age_while_held_q;
			end else if (debounce_cnt_q == lim) begin
				if (!first_press_only_q || click_cnt_q == '0) begin
					ev_d = kclp_pkg::EV_PRESS;
				end
				debounce_cnt_d = debounce_cnt_q + 8'd1;
				click_cnt_d = click_cnt_q + 3'd1;
				click_window_d = click_window_len_q;
				is_held_d = 1'b1;
				is_released_d = 1'b0;
			end else if (hold_time_q < hold_limit_q) begin
				hold_time_d = hold_time_q + 8'd1;
			end
		end else begin
			if (debounce_cnt_q != '0) begin
				debounce_cnt_d = debounce_cnt_q >> 1;
				if (release_age_q == '0) begin
					release_age_d = 8'd1;
					ev_d = kclp_pkg::EV_RELEASE;
					hold_time_d = 8'd0;
				end
			end else begin
				hold_time_d = hold_start_q;
				is_held_d = 1'b0;
				is_released_d = 1'b1;
				if (release_age_q < up_age_limit_q) begin
					release_age_d = release_age_q + 8'd1;
				end
				if (click_cnt_q == '0) begin
					release_age_d = 8'd1;
				end
			end
		end

		if (click_window_d != '0) begin
			click_window_d = click_window_d - 8'd1;
		end

		if ((click_window_d == '0 && is_released_d) || click_cnt_d >= kclp_pkg::MAX_CLICKS) begin
			if (click_cnt_d >= 3'd1 && click_cnt_d <= kclp_pkg::MAX_CLICKS) begin
				ev_d = kclp_pkg::EV_X1 + {1'b0, click_cnt_d} - 4'd1;
			end
			click_cnt_d = '0;
		end

		// Long press wins over any click or edge event of the same tick.
		if (hold_time_d == long_press_ticks_q) begin
			ev_d = kclp_pkg::EV_LONG;
			click_cnt_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_cnt_q <= '0;
			release_age_q <= '0;
			hold_time_q <= '0;
			click_cnt_q <= '0;
			click_window_q <= '0;
			is_held_q <= 1'b0;
			is_released_q <= 1'b0;
		end else if (advance) begin
			debounce_cnt_q <= debounce_cnt_d;
			release_age_q <= release_age_d;
			hold_time_q <= hold_time_d;
			click_cnt_q <= click_cnt_d;
			click_window_q <= click_window_d;
			is_held_q <= is_held_d;
			is_released_q <= is_released_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q <= ev_d;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.event_code = event_q;

	// Click events clear the count once it reaches five, so it never rests there.
	a_click_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		click_cnt_q < kclp_pkg::MAX_CLICKS)
		else $error("click count reached its clearing value");

	a_held_released_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(is_held_q && is_released_q))
		else $error("key flagged held and released at once");

	a_s1_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(pressed_s1))
		else $error("input stage lost a sample during an output stall");

	a_event_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> event_q <= kclp_pkg::EV_LONG)
		else $error("event code out of range");

	a_state_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(debounce_cnt_q) && $stable(click_cnt_q) && $stable(hold_time_q))
		else $error("key state changed without a transaction");

endmodule
